>>> rtl/core/wplg_pkg.sv
// Package for the wave-packet level guard: constants, register indexes and flag positions.
package wplg_pkg;

    // Field widths
    localparam int LEVEL_W   = 8;
    localparam int TEMP_W    = 16;
    localparam int ELAPSED_W = 18;
    localparam int FLAGS_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int TDATA_IN_W  = 24;
    localparam int TDATA_OUT_W = 24;
    localparam int TEMP_LIMIT_W = 15;
    localparam int CEILING_W = 9;

    // Level scale and step count
    localparam int PACKET_STEPS_DEFAULT = 10;
    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd200;
    localparam int CEILING_PER_TENTH = 20;

    // Saturation point of the millisecond counter
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 18'h3FFFF;

    // Unit scales for the limits
    localparam int MS_PER_SECOND   = 1000;
    localparam int TEMP_PER_DEGREE = 100;

    // Register defaults and the unprogrammed codes that select them
    localparam logic [7:0] SHUTOFF_DEFAULT     = 8'd70;
    localparam logic [7:0] TEMP_CUTOFF_DEFAULT = 8'd60;
    localparam logic [3:0] MAX_OUTPUT_DEFAULT  = 4'd9;
    localparam logic [7:0] UNPROG_BYTE         = 8'hFF;
    localparam logic [3:0] UNPROG_NIBBLE       = 4'hF;

    // Status flag positions
    localparam int FLAG_WORKING  = 0;
    localparam int FLAG_TIMEOUT  = 1;
    localparam int FLAG_OVERTEMP = 2;
    localparam logic [FLAGS_W-1:0] FLAGS_NONE = 3'b000;
    localparam logic [FLAGS_W-1:0] FLAGS_ALL  = 3'b111;

    // Operation codes carried in tuser
    typedef enum logic {
        OP_SET  = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHUTOFF     = 2'd0,
        CFG_TEMP_CUTOFF = 2'd1,
        CFG_MAX_OUTPUT  = 2'd2,
        CFG_LOGGING     = 2'd3
    } cfg_index_t;

endpackage

>>> rtl/core/wave_packet_level_guard.sv
// Wave-packet heater output channel with clamp, quantizer, auto-off and temperature guard.
// Path: input register, then the state and result register, then out on the master side.
// One word per cycle while m_tready is high; an empty input register fills while a result waits.
// The clamp and reciprocal multiply sit before the input register, the state update after it.
// Reset (aresetn low, synchronous): state and flags clear, registers take their defaults.
// Both stages come up empty; no clearing pass is needed.
module wave_packet_level_guard #(
    parameter int PACKET_STEPS = wplg_pkg::PACKET_STEPS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input word
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [wplg_pkg::TDATA_IN_W-1:0]     s_tdata,  // level_request[7:0], temperature[23:8]
    input  logic                                s_tuser,  // operation[0]
    // Result word
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [wplg_pkg::TDATA_OUT_W-1:0]    m_tdata,  // packet_steps[7:0],
                                                          // current_level[15:8],
                                                          // working_flag[16],
                                                          // timeout_flag[17],
                                                          // over_temp_flag[18], notify[19],
                                                          // zero[23:20]
    // Configuration write port
    input  logic                                cfg_wr_en,
    input  logic [wplg_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  logic [wplg_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    localparam int LW = wplg_pkg::LEVEL_W;
    localparam int EW = wplg_pkg::ELAPSED_W;
    localparam int TW = wplg_pkg::TEMP_W;
    localparam int LIMW = wplg_pkg::TEMP_LIMIT_W;
    localparam int CW = wplg_pkg::CEILING_W;

    // Level units per packet step, never below one
    localparam int STEP_RAW  = 200 / PACKET_STEPS;
    localparam int STEP_SIZE = (STEP_RAW == 0) ? 1 : STEP_RAW;
    // Reciprocal for an exact floor divide of any 8-bit value by STEP_SIZE
    localparam int RECIP_SHIFT = 2 * LW;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = RECIP_W + LW;
    localparam logic [RECIP_W-1:0] STEP_RECIP =
        RECIP_W'(((1 << RECIP_SHIFT) + STEP_SIZE - 1) / STEP_SIZE);

    // Register reset values in their scaled form
    localparam logic [EW-1:0] TIMEOUT_MS_RESET =
        EW'(int'(wplg_pkg::SHUTOFF_DEFAULT) * wplg_pkg::MS_PER_SECOND);
    localparam logic [LIMW-1:0] TEMP_LIMIT_RESET =
        LIMW'(int'(wplg_pkg::TEMP_CUTOFF_DEFAULT) * wplg_pkg::TEMP_PER_DEGREE);
    localparam logic [LW-1:0] CEILING_RESET = wplg_pkg::LEVEL_FULL;

    // Configuration registers, kept in scaled form
    logic [EW-1:0]   timeout_ms_reg, timeout_ms_next;
    logic [LIMW-1:0] temp_limit_reg, temp_limit_next;
    logic [LW-1:0]   ceiling_reg, ceiling_next;
    logic            channel_off_reg, channel_off_next;
    logic            logging_reg, logging_next;

    // Input stage
    logic                in_valid_reg;
    wplg_pkg::op_t       in_op_reg;
    logic                in_set_ok_reg;
    logic [LW-1:0]       in_quot_reg;
    logic [TW-1:0]       in_temp_reg;

    // Channel state and result
    logic [LW-1:0]                 step_reg, step_next;
    logic [LW-1:0]                 level_reg, level_next;
    logic [wplg_pkg::FLAGS_W-1:0]  flags_reg, flags_next;
    logic [EW-1:0]                 elapsed_reg, elapsed_next;
    logic                          notify_reg, notify_next;
    logic                          m_valid_reg;

    logic          in_load;
    logic          advance;
    logic [LW-1:0] req;
    logic [LW-1:0] clamped;
    logic [PROD_W-1:0] prod;
    logic          set_ok;

    logic [EW-1:0] elapsed_inc;
    logic          timed_out;
    logic          temp_bad;

    logic [LW-1:0] cfg_byte;
    logic [3:0]    cfg_tenths;
    logic [LW-1:0] cfg_shutoff_secs;
    logic [LW-1:0] cfg_temp_cutoff;
    logic [CW-1:0] cfg_ceiling;

    // Handshake: the input register refills as soon as its word moves on
    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_load  = s_tvalid && s_tready;

    // Decode configuration writes into scaled limits and the channel-off and logging bits
    always_comb begin
        cfg_byte         = cfg_wr_data[LW-1:0];
        cfg_tenths       = cfg_wr_data[3:0];
        cfg_shutoff_secs = (cfg_byte == wplg_pkg::UNPROG_BYTE) ? wplg_pkg::SHUTOFF_DEFAULT
                                                               : cfg_byte;
        cfg_temp_cutoff  = (cfg_byte == wplg_pkg::UNPROG_BYTE)
                         ? wplg_pkg::TEMP_CUTOFF_DEFAULT : cfg_byte;
        if (cfg_tenths == wplg_pkg::UNPROG_NIBBLE) begin
            cfg_tenths = wplg_pkg::MAX_OUTPUT_DEFAULT;
        end
        cfg_ceiling = (CW'(cfg_tenths) + CW'(1)) * CW'(wplg_pkg::CEILING_PER_TENTH);

        timeout_ms_next  = timeout_ms_reg;
        temp_limit_next  = temp_limit_reg;
        ceiling_next     = ceiling_reg;
        channel_off_next = channel_off_reg;
        logging_next     = logging_reg;
        if (cfg_wr_en) begin
            unique case (wplg_pkg::cfg_index_t'(cfg_wr_index))
                wplg_pkg::CFG_SHUTOFF: begin
                    timeout_ms_next = EW'(cfg_shutoff_secs) * EW'(wplg_pkg::MS_PER_SECOND);
                end
                wplg_pkg::CFG_TEMP_CUTOFF: begin
                    temp_limit_next = LIMW'(cfg_temp_cutoff) *
                                      LIMW'(wplg_pkg::TEMP_PER_DEGREE);
                end
                wplg_pkg::CFG_MAX_OUTPUT: begin
                    channel_off_next = (cfg_tenths == 4'd0);
                    ceiling_next = (cfg_ceiling > CW'(wplg_pkg::LEVEL_FULL))
                                 ? wplg_pkg::LEVEL_FULL : cfg_ceiling[LW-1:0];
                end
                wplg_pkg::CFG_LOGGING: begin
                    logging_next = cfg_wr_data[0];
                end
                default: begin
                    logging_next = logging_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_ms_reg  <= TIMEOUT_MS_RESET;
            temp_limit_reg  <= TEMP_LIMIT_RESET;
            ceiling_reg     <= CEILING_RESET;
            channel_off_reg <= 1'b0;
            logging_reg     <= 1'b0;
        end else begin
            timeout_ms_reg  <= timeout_ms_next;
            temp_limit_reg  <= temp_limit_next;
            ceiling_reg     <= ceiling_next;
            channel_off_reg <= channel_off_next;
            logging_reg     <= logging_next;
        end
    end

    // Clamp the requested level and divide it into packet steps
    always_comb begin
        req     = s_tdata[LW-1:0];
        set_ok  = (req <= wplg_pkg::LEVEL_FULL) && !channel_off_reg;
        clamped = (req > ceiling_reg) ? ceiling_reg : req;
        prod    = PROD_W'(clamped) * PROD_W'(STEP_RECIP);
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_load) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_op_reg     <= wplg_pkg::op_t'(s_tuser);
            in_set_ok_reg <= set_ok;
            in_quot_reg   <= prod[RECIP_SHIFT +: LW];
            in_temp_reg   <= s_tdata[LW +: TW];
        end
    end

    // Apply one set or tick word to the channel state
    always_comb begin
        elapsed_inc = (elapsed_reg == wplg_pkg::ELAPSED_MAX) ? elapsed_reg
                                                             : elapsed_reg + EW'(1);
        timed_out = (timeout_ms_reg != '0) && (elapsed_inc >= timeout_ms_reg);
        temp_bad  = (temp_limit_reg != '0) &&
                    (($signed(in_temp_reg) > $signed({1'b0, temp_limit_reg})) ||
                     ($signed(in_temp_reg) < $signed(TW'(1))));

        step_next    = step_reg;
        level_next   = level_reg;
        flags_next   = flags_reg;
        elapsed_next = elapsed_reg;
        notify_next  = 1'b0;

        if (in_op_reg == wplg_pkg::OP_SET) begin
            // Take the new level and restart the timer
            if (in_set_ok_reg) begin
                step_next    = in_quot_reg;
                level_next   = LW'((2 * LW)'(in_quot_reg) * (2 * LW)'(STEP_SIZE));
                elapsed_next = '0;
                if (in_quot_reg != '0) begin
                    flags_next = wplg_pkg::FLAGS_NONE;
                    flags_next[wplg_pkg::FLAG_WORKING] = 1'b1;
                end
            end
            if (channel_off_reg) begin
                step_next = '0;
            end
        end else begin
            // Count the millisecond and switch off on timeout or bad temperature
            elapsed_next = elapsed_inc;
            if (step_reg != '0) begin
                if (timed_out) begin
                    step_next   = '0;
                    level_next  = '0;
                    flags_next  = wplg_pkg::FLAGS_NONE;
                    flags_next[wplg_pkg::FLAG_TIMEOUT] = 1'b1;
                    notify_next = logging_reg;
                end else if (temp_bad) begin
                    step_next   = '0;
                    level_next  = '0;
                    flags_next[wplg_pkg::FLAG_WORKING]  = 1'b0;
                    flags_next[wplg_pkg::FLAG_OVERTEMP] = 1'b1;
                    notify_next = logging_reg;
                end
            end
            if (channel_off_reg) begin
                flags_next = wplg_pkg::FLAGS_ALL;
            end
        end
    end

    // State and result register; the state is the result that is shown
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            level_reg   <= '0;
            flags_reg   <= wplg_pkg::FLAGS_NONE;
            elapsed_reg <= '0;
            notify_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                step_reg    <= step_next;
                level_reg   <= level_next;
                flags_reg   <= flags_next;
                elapsed_reg <= elapsed_next;
                notify_reg  <= notify_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, notify_reg, flags_reg, level_reg, step_reg};

`ifndef SYNTHESIS
    // An empty input register always takes a word
    assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");

    // Every word that leaves the input stage shows up as a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
        else $error("advanced word did not reach the result register");

    // Set words never raise notify
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (in_op_reg == wplg_pkg::OP_SET)) |=> !notify_reg)
        else $error("notify raised on a set word");

    // A tick advances the millisecond counter by one, saturating
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (in_op_reg == wplg_pkg::OP_TICK)) |=>
        ((elapsed_reg == wplg_pkg::ELAPSED_MAX) ||
         (elapsed_reg == EW'($past(elapsed_reg) + EW'(1)))))
        else $error("elapsed counter did not advance on a tick");
`endif

endmodule

>>> dv/tb_wave_packet_level_guard.sv
// Self-checking testbench for the wave-packet level guard: directed and random traffic.
module tb_wave_packet_level_guard;
    timeunit 1ns;
    timeprecision 1ps;

    import wplg_pkg::*;

    localparam int PACKET_STEPS = PACKET_STEPS_DEFAULT;
    localparam int STEP_SIZE    = (int'(LEVEL_FULL) / PACKET_STEPS == 0) ?
                                  1 : int'(LEVEL_FULL) / PACKET_STEPS;
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        logic [LEVEL_W-1:0] packet_steps;
        logic [LEVEL_W-1:0] current_level;
        logic               working;
        logic               timeout;
        logic               over_temp;
        logic               notify;
    } channel_result_t;

    logic                    aclk;
    logic                    aresetn      = 1'b0;
    logic                    s_tvalid     = 1'b0;
    logic                    s_tready;
    logic [TDATA_IN_W-1:0]   s_tdata      = '0;
    logic                    s_tuser      = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready     = 1'b0;
    logic [TDATA_OUT_W-1:0]  m_tdata;
    logic                    cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_wr_data  = '0;

    // Channel model: configuration and state
    logic [7:0]              mdl_shutoff_secs;
    logic [7:0]              mdl_temp_cutoff;
    logic [3:0]              mdl_max_out;
    logic                    mdl_log;
    logic [LEVEL_W-1:0]      mdl_steps;
    logic [LEVEL_W-1:0]      mdl_reported;
    logic [FLAGS_W-1:0]      mdl_flags;
    logic [ELAPSED_W-1:0]    mdl_elapsed;

    channel_result_t         expected_results[$];
    int                      mismatch_count = 0;
    int                      result_count   = 0;
    int                      send_idle_pct  = 0;
    int                      recv_idle_pct  = 0;
    int                      rx_hold_cycles = 0;

    wave_packet_level_guard u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),   // level_request[7:0], temperature[23:8]
        .s_tuser      (s_tuser),   // operation[0]
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),   // packet_steps[7:0], current_level[15:8], working[16],
                                   // timeout[17], over_temp[18], notify[19]
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Advance the channel model by one word and return the state it shows
    function automatic channel_result_t predict_channel(input op_t op,
                                                        input logic [7:0] level,
                                                        input logic [15:0] temp);
        channel_result_t r;
        int ceiling;
        int clamped;
        int temp_c;
        logic note;
        note = 1'b0;
        if (op == OP_SET) begin
            if (int'(level) <= int'(LEVEL_FULL) && mdl_max_out != 0) begin
                ceiling = (int'(mdl_max_out) + 1) * CEILING_PER_TENTH;
                if (ceiling > int'(LEVEL_FULL)) ceiling = int'(LEVEL_FULL);
                clamped = (int'(level) > ceiling) ? ceiling : int'(level);
                mdl_steps    = 8'(clamped / STEP_SIZE);
                mdl_reported = 8'(int'(mdl_steps) * STEP_SIZE);
                mdl_elapsed  = '0;
                if (mdl_steps != 0) begin
                    mdl_flags = FLAGS_NONE;
                    mdl_flags[FLAG_WORKING] = 1'b1;
                end
            end
            if (mdl_max_out == 0) mdl_steps = '0;
        end else begin
            temp_c = $signed(temp);
            if (mdl_elapsed != ELAPSED_MAX) mdl_elapsed = mdl_elapsed + 1'b1;
            if (mdl_steps != 0) begin
                // Timeout takes priority over the temperature guard
                if (mdl_shutoff_secs != 0 &&
                    int'(mdl_elapsed) >= int'(mdl_shutoff_secs) * MS_PER_SECOND) begin
                    mdl_steps    = '0;
                    mdl_reported = '0;
                    mdl_flags    = FLAGS_NONE;
                    mdl_flags[FLAG_TIMEOUT] = 1'b1;
                    note = mdl_log;
                end else if (mdl_temp_cutoff != 0 &&
                             (temp_c > int'(mdl_temp_cutoff) * TEMP_PER_DEGREE ||
                              temp_c < 1)) begin
                    mdl_steps    = '0;
                    mdl_reported = '0;
                    mdl_flags[FLAG_WORKING]  = 1'b0;
                    mdl_flags[FLAG_OVERTEMP] = 1'b1;
                    note = mdl_log;
                end
            end
            if (mdl_max_out == 0) mdl_flags = FLAGS_ALL;
        end
        r.packet_steps  = mdl_steps;
        r.current_level = mdl_reported;
        r.working       = mdl_flags[FLAG_WORKING];
        r.timeout       = mdl_flags[FLAG_TIMEOUT];
        r.over_temp     = mdl_flags[FLAG_OVERTEMP];
        r.notify        = note;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        mismatch_count++;
        $display("%0t ns: word %0d %s got %0d want %0d",
                 $time, result_count, field, got, want);
    endtask

    // Predict on every accepted input word
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            expected_results.push_back(predict_channel(op_t'(s_tuser), s_tdata[7:0],
                                                       s_tdata[23:8]));
    end

    // Compare every accepted result word with the oldest prediction
    always @(posedge aclk) begin
        channel_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected word", int'(m_tdata), 0);
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[7:0] != want.packet_steps)
                    report_mismatch("packet_steps", m_tdata[7:0], want.packet_steps);
                if (m_tdata[15:8] != want.current_level)
                    report_mismatch("current_level", m_tdata[15:8], want.current_level);
                if (m_tdata[16] != want.working)
                    report_mismatch("working_flag", m_tdata[16], want.working);
                if (m_tdata[17] != want.timeout)
                    report_mismatch("timeout_flag", m_tdata[17], want.timeout);
                if (m_tdata[18] != want.over_temp)
                    report_mismatch("over_temp_flag", m_tdata[18], want.over_temp);
                if (m_tdata[19] != want.notify)
                    report_mismatch("notify", m_tdata[19], want.notify);
            end
            result_count++;
        end
    end

    // Receiver: random stalls, or a counted hold-off stretch when requested
    always @(posedge aclk) begin
        if (rx_hold_cycles > 0) begin
            m_tready <= 1'b0;
            rx_hold_cycles = rx_hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one word, with random gaps ahead of it, and hold until accepted
    task automatic send_word(input op_t op, input logic [7:0] level, input logic [15:0] temp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {temp, level};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drop valid and wait for every predicted word to come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [7:0] value);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_SHUTOFF:     mdl_shutoff_secs = (value == UNPROG_BYTE) ?
                                                SHUTOFF_DEFAULT : value;
            CFG_TEMP_CUTOFF: mdl_temp_cutoff  = (value == UNPROG_BYTE) ?
                                                TEMP_CUTOFF_DEFAULT : value;
            CFG_MAX_OUTPUT:  mdl_max_out      = (value[3:0] == UNPROG_NIBBLE) ?
                                                MAX_OUTPUT_DEFAULT : value[3:0];
            CFG_LOGGING:     mdl_log          = value[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Reprogram all registers once the channel is idle
    task automatic configure_channel(input logic [7:0] shutoff_secs,
                                     input logic [7:0] temp_cutoff,
                                     input logic [7:0] max_out, input logic [7:0] logging);
        wait_drained();
        write_register(CFG_SHUTOFF, shutoff_secs);
        write_register(CFG_TEMP_CUTOFF, temp_cutoff);
        write_register(CFG_MAX_OUTPUT, max_out);
        write_register(CFG_LOGGING, logging);
    endtask

    // Mostly in-range temperatures, some at the limits, some noise
    function automatic logic [15:0] random_temperature();
        int limit;
        int pick;
        limit = int'(mdl_temp_cutoff) * TEMP_PER_DEGREE;
        pick  = $urandom_range(99);
        if (pick < 10 || limit == 0) return 16'($urandom);
        if (pick < 16) return 16'($urandom_range(0, 1));
        if (pick < 24) return 16'(limit - 1 + $urandom_range(0, 2));
        return 16'($urandom_range(1, limit));
    endfunction

    function automatic logic [7:0] extreme_byte();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd254;
            3: return 8'd255;
            default: return 8'($urandom_range(2, 253));
        endcase
    endfunction

    // Reset values; levels across the range, ignored sets above full scale
    task automatic check_set_quantization();
        send_word(OP_SET, 8'd0, 16'd0);
        send_word(OP_SET, 8'd1, 16'hFFFF);
        send_word(OP_SET, 8'd19, 16'd0);
        send_word(OP_SET, 8'd20, 16'd0);
        send_word(OP_SET, 8'd199, 16'd0);
        send_word(OP_SET, 8'd200, 16'd0);
        send_word(OP_SET, 8'd201, 16'd0);
        send_word(OP_SET, 8'd255, 16'd0);
        send_word(OP_TICK, 8'hFF, 16'd2000);
    endtask

    // Temperature limits, disabled check, unprogrammed codes and logging
    task automatic check_temperature_guard();
        send_word(OP_SET, 8'd200, 16'd0);
        send_word(OP_TICK, 8'd0, 16'd6000);
        send_word(OP_TICK, 8'd0, 16'd6001);
        send_word(OP_TICK, 8'd0, 16'd6001);
        send_word(OP_SET, 8'd100, 16'd0);
        send_word(OP_TICK, 8'd0, 16'd1);
        send_word(OP_TICK, 8'd0, 16'd0);
        send_word(OP_SET, 8'd40, 16'd0);
        send_word(OP_TICK, 8'd0, 16'h8000);
        configure_channel(8'd255, 8'd255, 8'd15, 8'h01);
        send_word(OP_SET, 8'd100, 16'd0);
        send_word(OP_TICK, 8'd0, 16'd6001);
        configure_channel(8'd70, 8'd0, 8'd9, 8'hFE);
        send_word(OP_SET, 8'd100, 16'd0);
        send_word(OP_TICK, 8'd0, 16'h7FFF);
        send_word(OP_TICK, 8'd0, 16'h8000);
        configure_channel(8'd70, 8'd254, 8'd9, 8'd1);
        send_word(OP_SET, 8'd200, 16'd0);
        send_word(OP_TICK, 8'd0, 16'd25400);
        send_word(OP_TICK, 8'd0, 16'd25401);
    endtask

    // Ceiling settings: disabled, low, saturating, and a disabling code with its upper nibble set
    task automatic check_output_ceiling();
        configure_channel(8'd70, 8'd60, 8'd0, 8'd0);
        send_word(OP_SET, 8'd100, 16'd0);
        send_word(OP_TICK, 8'd0, 16'd2000);
        configure_channel(8'd70, 8'd60, 8'd1, 8'd0);
        send_word(OP_SET, 8'd200, 16'd0);
        send_word(OP_TICK, 8'd0, 16'd2000);
        configure_channel(8'd70, 8'd60, 8'd4, 8'd0);
        send_word(OP_SET, 8'd255, 16'd0);
        send_word(OP_SET, 8'd90, 16'd0);
        configure_channel(8'd70, 8'd60, 8'd12, 8'd0);
        send_word(OP_SET, 8'd200, 16'd0);
        configure_channel(8'd70, 8'd60, 8'hF0, 8'd0);
        send_word(OP_SET, 8'd150, 16'd0);
        send_word(OP_TICK, 8'd0, 16'd2000);
    endtask

    // One-second auto-off with logging; timeout beats overtemperature
    task automatic check_shutoff_timeout();
        configure_channel(8'd1, 8'd254, 8'd9, 8'd1);
        send_word(OP_SET, 8'd200, 16'd0);
        repeat (999) send_word(OP_TICK, 8'($urandom), 16'd2500);
        send_word(OP_TICK, 8'd0, 16'h7FFF);
        send_word(OP_TICK, 8'd0, 16'h7FFF);
    endtask

    // Hold the receiver off long enough that the block stalls its input
    task automatic check_input_stall();
        configure_channel(8'd70, 8'd60, 8'd9, 8'd0);
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        rx_hold_cycles = 60;
        send_word(OP_SET, 8'd120, 16'd0);
        repeat (40) send_word(OP_TICK, 8'd0, random_temperature());
    endtask

    // Set then tick bursts under random settings, across the idling patterns
    task automatic check_random_traffic();
        int send_pcts[3] = '{20, 77, 0};
        int recv_pcts[3] = '{77, 20, 0};
        int count;
        int burst;
        logic [7:0] level;
        for (int m = 0; m < 3; m++) begin
            send_idle_pct = send_pcts[m];
            recv_idle_pct = recv_pcts[m];
            for (int p = 0; p < 4; p++) begin
                configure_channel(extreme_byte(), extreme_byte(),
                                  ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom),
                                  8'($urandom));
                count = 0;
                while (count < 70) begin
                    level = ($urandom_range(99) < 85) ? 8'($urandom_range(0, 200)) :
                                                       8'($urandom_range(201, 255));
                    send_word(OP_SET, level, 16'($urandom));
                    if (level <= LEVEL_FULL) count++;
                    burst = $urandom_range(0, 24);
                    repeat (burst) begin
                        send_word(OP_TICK, 8'($urandom), random_temperature());
                        count++;
                    end
                end
            end
        end
    endtask

    initial begin
        mdl_shutoff_secs = SHUTOFF_DEFAULT;
        mdl_temp_cutoff  = TEMP_CUTOFF_DEFAULT;
        mdl_max_out      = MAX_OUTPUT_DEFAULT;
        mdl_log          = 1'b0;
        mdl_steps        = '0;
        mdl_reported     = '0;
        mdl_flags        = FLAGS_NONE;
        mdl_elapsed      = '0;
        send_idle_pct    = 20;
        recv_idle_pct    = 77;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        check_set_quantization();
        check_temperature_guard();
        check_output_ceiling();
        check_shutoff_timeout();
        check_input_stall();
        check_random_traffic();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_wave_packet_level_guard: PASS");
        end else begin
            $display("tb_wave_packet_level_guard: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(25_000_000);
        $display("tb_wave_packet_level_guard: FAIL");
        $finish;
    end

endmodule

>>> wave_packet_level_guard.f
rtl/core/wplg_pkg.sv
rtl/core/wave_packet_level_guard.sv
dv/tb_wave_packet_level_guard.sv
